// File: hdl/brfifo_pkg.sv
// brfifo_pkg: shared types, codes and index arithmetic for the byte ring FIFO.
// No dependencies; imported by brfifo_ram and byte_ring_fifo_with_chop_off_unit.
package brfifo_pkg;

    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        FN_PUT      = 3'd0,
        FN_GET      = 3'd1,
        FN_REMOVE   = 3'd2,
        FN_FLUSH    = 3'd3,
        FN_BEGIN    = 3'd4,
        FN_COMMIT   = 3'd5,
        FN_ROLLBACK = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_EMPTY    = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        CHOP_NONE = 2'd0,
        CHOP_CHAR = 2'd1,
        CHOP_LEN  = 2'd2
    } t_chop_mode;

    typedef enum logic [1:0] {
        CFG_MODE = 2'd0,
        CFG_CHAR = 2'd1,
        CFG_LEN  = 2'd2,
        CFG_SIZE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [7:0]       wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    // Bytes held between tail and head in a ring of the given size.
    function automatic logic [CNT_W-1:0] fill_of(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] tail,
                                                 input logic [CNT_W-1:0] size);
        logic [CNT_W-1:0] h;
        logic [CNT_W-1:0] t;
        h = {1'b0, head};
        t = {1'b0, tail};
        if (h >= t) begin
            return h - t;
        end
        return size - t + h;
    endfunction

    // idx + amt modulo size, valid while idx + amt < 2 * size.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] amt,
                                                  input logic [CNT_W-1:0] size);
        logic [CNT_W:0] sum;
        sum = {2'b00, idx} + {1'b0, amt};
        if (sum >= {1'b0, size}) begin
            sum = sum - {1'b0, size};
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: hdl/byte_ring_fifo_with_chop_off_unit.sv
// Byte ring FIFO with drop-oldest chop policy. Put, remove, flush, begin, commit,
// rollback and chopping length-mode puts register their result in the cycle after
// the accepted beat; a get on a non-empty ring passes through S_GET for the store read.
// A full put in character mode scans the store one byte per cycle until it finds a
// delimiter or reaches the head, and its result is registered when the scan ends.
// Synchronous active-low reset empties ring, restores regs.
module byte_ring_fifo_with_chop_off_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] data_byte, [18:8] remove_count, zero fill
    input  logic [2:0]  i_s_tuser,   // [2:0] func
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [0] ok, [8:1] read_byte, [18:9] fill_count,
                                     // [28:19] free_count, [29] is_empty, [31:30] error_code
);
    import brfifo_pkg::*;

    // ---------------- configuration registers ----------------
    t_chop_mode       r_mode;
    logic [7:0]       r_char;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_size;     // used_size saturated to [2, DEPTH]
    logic [CNT_W-1:0] cfg_size;

    // ---------------- ring pointers and transaction ----------------
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic             r_txn_open, n_txn_open;
    logic [IDX_W-1:0] r_txn_head, n_txn_head;

    // ---------------- control ----------------
    t_state r_state, n_state;

    // latched request operand for the scan
    logic [7:0] r_data, n_data;

    // character scan: issue stage (address) and check stage (returned byte)
    logic [IDX_W-1:0] r_scan_pos, n_scan_pos;
    logic [IDX_W-1:0] r_scan_cnt, n_scan_cnt;
    logic             r_chk_valid, n_chk_valid;
    logic [IDX_W-1:0] r_chk_pos, n_chk_pos;
    logic [IDX_W-1:0] r_chk_cnt, n_chk_cnt;

    // output register
    logic             r_out_valid, n_out_valid;
    logic             r_out_ok, n_out_ok;
    logic [7:0]       r_out_byte, n_out_byte;
    logic [IDX_W-1:0] r_out_fill, n_out_fill;
    logic [IDX_W-1:0] r_out_free, n_out_free;
    logic             r_out_empty, n_out_empty;
    t_err             r_out_err, n_out_err;

    // ---------------- request decode ----------------
    t_func            in_func;
    logic [7:0]       in_data;
    logic [CNT_W-1:0] in_rcount;
    logic             s_acc;

    assign in_func   = t_func'(i_s_tuser);
    assign in_data   = i_s_tdata[7:0];
    assign in_rcount = i_s_tdata[18:8];

    // result slot is free or drains this cycle
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // ---------------- byte store ----------------
    t_ram_req   ram_req;
    logic [7:0] ram_rdata;

    brfifo_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // ---------------- shared arithmetic ----------------
    logic [CNT_W-1:0] fill_cur;
    logic [IDX_W-1:0] head_nx;
    logic             full;
    logic [CNT_W-1:0] unit;
    logic             scan_issue;
    logic             scan_hit;
    logic             scan_miss;
    logic [CNT_W-1:0] fill_new;

    assign fill_cur = fill_of(r_head, r_tail, r_size);
    assign head_nx  = wrap_add(r_head, CNT_W'(1), r_size);
    assign full     = (head_nx == r_tail);
    assign unit     = (r_len == '0) ? CNT_W'(1) : r_len;

    // scan stops issuing once it reaches the head
    assign scan_issue = (r_scan_pos != r_head);
    // a delimiter only counts after more than one byte was passed
    assign scan_hit   = r_chk_valid && (ram_rdata == r_char) && (r_chk_cnt > IDX_W'(1));
    assign scan_miss  = !scan_issue && !r_chk_valid;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc && in_func == FN_GET && r_head != r_tail) begin
                    n_state = S_GET;
                end else if (s_acc && in_func == FN_PUT && full && r_mode == CHOP_CHAR) begin
                    n_state = S_SCAN;
                end
            end
            S_GET: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (scan_hit || scan_miss) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_txn_open  = r_txn_open;
        n_txn_head  = r_txn_head;
        n_data      = r_data;
        n_scan_pos  = r_scan_pos;
        n_scan_cnt  = r_scan_cnt;
        n_chk_valid = 1'b0;
        n_chk_pos   = r_scan_pos;
        n_chk_cnt   = r_scan_cnt;
        n_out_ok    = 1'b1;
        n_out_byte  = 8'd0;
        n_out_err   = ERR_NONE;
        n_out_valid = r_out_valid && !i_m_tready;
        ram_req.we    = 1'b0;
        ram_req.waddr = r_head;
        ram_req.wdata = in_data;
        ram_req.raddr = r_tail;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_out_valid = 1'b1;
                    case (in_func)
                        FN_PUT: begin
                            if (!full) begin
                                ram_req.we = 1'b1;
                                n_head     = head_nx;
                            end else if (r_mode == CHOP_CHAR) begin
                                n_out_valid = 1'b0;
                                n_data      = in_data;
                                n_scan_pos  = r_tail;
                                n_scan_cnt  = '0;
                            end else if (r_mode == CHOP_LEN && fill_cur != '0) begin
                                // drop one unit, or everything if the unit covers it all
                                n_tail     = (unit < fill_cur) ?
                                             wrap_add(r_tail, unit, r_size) : r_head;
                                ram_req.we = 1'b1;
                                n_head     = head_nx;
                            end else begin
                                n_out_ok  = 1'b0;
                                n_out_err = ERR_OVERFLOW;
                            end
                        end
                        FN_GET: begin
                            if (r_head == r_tail) begin
                                n_out_ok  = 1'b0;
                                n_out_err = ERR_EMPTY;
                            end else begin
                                // byte arrives next cycle; result completes in S_GET
                                n_out_valid = 1'b0;
                                n_tail      = wrap_add(r_tail, CNT_W'(1), r_size);
                            end
                        end
                        FN_REMOVE: begin
                            n_tail = (in_rcount >= fill_cur) ?
                                     r_head : wrap_add(r_tail, in_rcount, r_size);
                        end
                        FN_FLUSH: begin
                            n_tail = r_head;
                        end
                        FN_BEGIN: begin
                            // a second begin rolls back the open transaction first
                            n_head     = r_txn_open ? r_txn_head : r_head;
                            n_txn_head = r_txn_open ? r_txn_head : r_head;
                            n_txn_open = 1'b1;
                        end
                        FN_COMMIT: begin
                            n_txn_open = 1'b0;
                        end
                        FN_ROLLBACK: begin
                            if (r_txn_open) begin
                                n_head     = r_txn_head;
                                n_txn_open = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_GET: begin
                n_out_valid = 1'b1;
                n_out_byte  = ram_rdata;
            end
            S_SCAN: begin
                ram_req.raddr = r_scan_pos;
                ram_req.wdata = r_data;
                n_chk_valid   = scan_issue;
                if (scan_issue) begin
                    n_scan_pos = wrap_add(r_scan_pos, CNT_W'(1), r_size);
                    n_scan_cnt = r_scan_cnt + IDX_W'(1);
                end
                if (scan_hit) begin
                    // keep the delimiter, then store the new byte
                    n_tail      = r_chk_pos;
                    ram_req.we  = 1'b1;
                    n_head      = head_nx;
                    n_out_valid = 1'b1;
                end else if (scan_miss) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = 1'b0;
                    n_out_err   = ERR_OVERFLOW;
                end
            end
            default: begin
            end
        endcase

        fill_new    = fill_of(n_head, n_tail, r_size);
        n_out_fill  = fill_new[IDX_W-1:0];
        n_out_free  = IDX_W'(r_size - CNT_W'(1) - fill_new);
        n_out_empty = (n_head == n_tail);
    end

    // saturate the ring size to [2, DEPTH]
    always_comb begin
        cfg_size = i_cfg_data;
        if (i_cfg_data < CNT_W'(2)) begin
            cfg_size = CNT_W'(2);
        end else if (i_cfg_data > CNT_W'(DEPTH)) begin
            cfg_size = CNT_W'(DEPTH);
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_txn_open  <= 1'b0;
            r_txn_head  <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= CHOP_NONE;
            r_char      <= 8'd0;
            r_len       <= CNT_W'(1);
            r_size      <= CNT_W'(DEPTH);
        end else begin
            r_state     <= n_state;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && t_cfg_idx'(i_cfg_idx) == CFG_SIZE) begin
                // a size change empties the ring and drops the transaction
                r_head     <= '0;
                r_tail     <= '0;
                r_txn_open <= 1'b0;
                r_txn_head <= '0;
            end else begin
                r_head     <= n_head;
                r_tail     <= n_tail;
                r_txn_open <= n_txn_open;
                r_txn_head <= n_txn_head;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MODE: r_mode <= t_chop_mode'(i_cfg_data[1:0]);
                    CFG_CHAR: r_char <= i_cfg_data[7:0];
                    CFG_LEN:  r_len  <= i_cfg_data;
                    CFG_SIZE: r_size <= cfg_size;
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_scan_pos <= n_scan_pos;
        r_scan_cnt <= n_scan_cnt;
        r_chk_pos  <= n_chk_pos;
        r_chk_cnt  <= n_chk_cnt;
        if (n_out_valid && !(r_out_valid && !i_m_tready)) begin
            r_out_ok    <= n_out_ok;
            r_out_byte  <= n_out_byte;
            r_out_fill  <= n_out_fill;
            r_out_free  <= n_out_free;
            r_out_empty <= n_out_empty;
            r_out_err   <= n_out_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_err, r_out_empty, r_out_free, r_out_fill, r_out_byte, r_out_ok};

    // ---------------- assertions ----------------
    a_head_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < r_size && r_tail < r_size)
        else $error("ring pointer beyond used size");

    a_txn_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_txn_head < r_size)
        else $error("saved head beyond used size");

    a_get_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GET |=> r_out_valid)
        else $error("get completed without a result");

    a_scan_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> !r_out_valid)
        else $error("result slot busy during scan");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> r_state == S_IDLE)
        else $error("request taken while busy");

endmodule

// File: hdl/brfifo_ram.sv
// brfifo_ram: byte store of the ring, one write port and one registered read port.
// Depends on brfifo_pkg (DEPTH, t_ram_req).
module brfifo_ram (
    input  logic                  i_clk,
    input  brfifo_pkg::t_ram_req  i_req,
    output logic [7:0]            o_rdata
);
    import brfifo_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read; a read of the entry written in the same beat returns its old byte
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: test/brfifo_result_monitor.sv
// brfifo_result_monitor: watches register writes, request beats and result beats of
// the byte ring FIFO, predicts every result and compares it field by field.
// Depends on brfifo_pkg for sizes and codes.
module brfifo_result_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] data_byte, [18:8] remove_count, zero fill
    input  logic [2:0]  i_s_tuser,   // [2:0] func
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [0] ok, [8:1] read_byte, [18:9] fill_count,
                                     // [28:19] free_count, [29] is_empty, [31:30] error_code
    output int          o_pending,
    output int          o_err_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import brfifo_pkg::*;

    typedef struct {
        logic       ok;
        logic [7:0] rbyte;
        logic [9:0] fill;
        logic [9:0] free;
        logic       empty;
        logic [1:0] err;
    } fifo_resp_t;

    fifo_resp_t  resp_fifo [$];
    logic [7:0]  mem_copy [DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned txn_head;
    bit          txn_open;
    logic [1:0]  mode_r;
    logic [7:0]  char_r;
    logic [10:0] len_r;
    logic [10:0] size_r;
    int          err_count = 0;

    assign o_err_count = err_count;

    function automatic int unsigned held_bytes(input int unsigned size);
        return (head >= tail) ? head - tail : size - tail + head;
    endfunction

    // Applies one request to the shadow ring and returns the result it must produce.
    function automatic fifo_resp_t next_response(input logic [2:0]  func,
                                                 input logic [7:0]  data,
                                                 input logic [10:0] rcount);
        fifo_resp_t  r;
        int unsigned size;
        int unsigned nxt;
        int unsigned pos;
        int unsigned passed;
        int unsigned held;
        int unsigned unit;
        bit          room;

        // effective size saturates to [2, DEPTH]
        size = size_r;
        if (size < 2) size = 2;
        if (size > DEPTH) size = DEPTH;
        if (head >= size) head = head % size;
        if (tail >= size) tail = tail % size;
        if (txn_head >= size) txn_head = txn_head % size;

        r.ok    = 1'b1;
        r.rbyte = 8'h00;
        r.err   = ERR_NONE;

        case (func)
            FN_PUT: begin
                nxt  = (head + 1 >= size) ? 0 : head + 1;
                room = (nxt != tail);
                if (!room && mode_r == CHOP_CHAR) begin
                    // walk from the tail; keep the first delimiter past the second byte
                    pos    = tail;
                    passed = 0;
                    while (!room && pos != head && passed <= size) begin
                        if (mem_copy[pos] == char_r && passed > 1) begin
                            tail = pos;
                            room = 1'b1;
                        end else begin
                            pos = (pos + 1 >= size) ? 0 : pos + 1;
                            passed++;
                        end
                    end
                end else if (!room && mode_r == CHOP_LEN) begin
                    held = held_bytes(size);
                    unit = (len_r == 0) ? 1 : len_r;
                    if (unit < held) begin
                        tail = tail + unit;
                        if (tail >= size) tail = tail - size;
                        room = 1'b1;
                    end else if (held >= 1) begin
                        tail = head;
                        room = 1'b1;
                    end
                end
                if (room) begin
                    mem_copy[head] = data;
                    head = nxt;
                end else begin
                    r.ok  = 1'b0;
                    r.err = ERR_OVERFLOW;
                end
            end
            FN_GET: begin
                if (tail == head) begin
                    r.ok  = 1'b0;
                    r.err = ERR_EMPTY;
                end else begin
                    r.rbyte = mem_copy[tail];
                    tail = (tail + 1 >= size) ? 0 : tail + 1;
                end
            end
            FN_REMOVE: begin
                held = held_bytes(size);
                if (rcount >= held) tail = head;
                else tail = (tail + rcount) % size;
            end
            FN_FLUSH: begin
                tail = head;
            end
            FN_BEGIN: begin
                if (txn_open) head = txn_head;
                txn_head = head;
                txn_open = 1'b1;
            end
            FN_COMMIT: begin
                txn_open = 1'b0;
            end
            FN_ROLLBACK: begin
                if (txn_open) begin
                    head = txn_head;
                    txn_open = 1'b0;
                end
            end
            default: ;
        endcase

        held    = held_bytes(size);
        r.fill  = 10'(held);
        r.free  = 10'(size - 1 - held);
        r.empty = (head == tail);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [10:0] want,
                               input logic [10:0] got);
        if (got !== want) begin
            err_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        fifo_resp_t got;
        fifo_resp_t want;
        if (!i_rst_n) begin
            foreach (mem_copy[k]) mem_copy[k] = 8'h00;
            head     = 0;
            tail     = 0;
            txn_head = 0;
            txn_open = 1'b0;
            mode_r   = CHOP_NONE;
            char_r   = 8'h00;
            len_r    = 11'd1;
            size_r   = 11'(DEPTH);
            resp_fifo.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: mode_r = i_cfg_data[1:0];
                    CFG_CHAR: char_r = i_cfg_data[7:0];
                    CFG_LEN:  len_r  = i_cfg_data;
                    CFG_SIZE: begin
                        // a size change empties the ring and closes the transaction
                        size_r   = i_cfg_data;
                        head     = 0;
                        tail     = 0;
                        txn_head = 0;
                        txn_open = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.ok    = i_m_tdata[0];
                got.rbyte = i_m_tdata[8:1];
                got.fill  = i_m_tdata[18:9];
                got.free  = i_m_tdata[28:19];
                got.empty = i_m_tdata[29];
                got.err   = i_m_tdata[31:30];
                if (resp_fifo.size() == 0) begin
                    err_count++;
                    $error("result beat with no request outstanding");
                end else begin
                    want = resp_fifo.pop_front();
                    check_field("ok", want.ok, got.ok);
                    check_field("read_byte", want.rbyte, got.rbyte);
                    check_field("fill_count", want.fill, got.fill);
                    check_field("free_count", want.free, got.free);
                    check_field("is_empty", want.empty, got.empty);
                    check_field("error_code", want.err, got.err);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                resp_fifo.push_back(next_response(i_s_tuser, i_s_tdata[7:0], i_s_tdata[18:8]));
            end
        end
        o_pending <= resp_fifo.size();
    end

endmodule

// File: test/tb_top.sv
// tb_top: clock, reset, request stimulus, result back-pressure and verdict for
// byte_ring_fifo_with_chop_off_unit. Needs brfifo_pkg, the unit and brfifo_result_monitor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import brfifo_pkg::*;

    localparam logic [2:0] FN_UNUSED       = 3'd7;  // undecoded func, acts as a no-op
    localparam logic [1:0] CHOP_UNKNOWN    = 2'd3;  // undecoded mode, acts as no chopping
    localparam int         RANDOM_BEATS    = 800;
    localparam int         PHASES          = 12;
    localparam int         HOLD_OFF_CYCLES = 250;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = CFG_MODE;
    logic [10:0] i_cfg_data = 11'd0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = 24'd0;
    logic [2:0]  i_s_tuser  = FN_PUT;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;

    int          pending;
    int          err_count;
    int          hold_req   = 0;      // bumped to ask the result side for one long stall
    bit          idle_en    = 1'b1;   // random gaps on both sides while set
    int          beats_sent = 0;
    logic [1:0]  cur_mode   = CHOP_NONE;
    logic [7:0]  cur_char   = 8'h00;
    int          cur_size   = DEPTH;

    always #6 i_clk = ~i_clk;

    byte_ring_fifo_with_chop_off_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    brfifo_result_monitor u_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_pending   (pending),
        .o_err_count (err_count)
    );

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // In delimiter mode a quarter of the bytes are the delimiter, so chops find one.
    function automatic logic [7:0] pick_byte();
        if (cur_mode == CHOP_CHAR && $urandom_range(0, 3) == 0) return cur_char;
        return 8'($urandom);
    endfunction

    // Offer one request beat and hold it until the unit takes it.
    // Called at a clock edge; returns at the edge where the beat was accepted.
    task automatic send_req(input logic [2:0] func, input logic [7:0] data,
                            input logic [10:0] count);
        int gap;
        gap = idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {5'd0, count, data};
        do @(posedge i_clk); while (!o_s_tready);
        beats_sent++;
    endtask

    // Stop offering and wait until every predicted result beat has come back.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Result side: random stalls while idling is on, plus one long hold-off per request.
    // Exactly one assignment to tready per pass, so no same-step glitches.
    initial begin
        int served;
        served = 0;
        forever begin
            if (hold_req != served) begin
                served = hold_req;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Stimulus
    initial begin
        int          n;
        int          kind;
        int          pick;
        int          target;
        logic [1:0]  mode;
        logic [7:0]  dchar;
        logic [10:0] clen;
        logic [10:0] csize;
        bit          with_size;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: reset registers (no chopping, full 1024-byte ring) ---
        // empty-ring corners
        send_req(FN_GET, 8'hA5, 11'd0);          // get on empty -> error
        send_req(FN_REMOVE, 8'h00, 11'd0);       // remove nothing
        send_req(FN_REMOVE, 8'hFF, 11'h7FF);     // remove beyond fill, widest count
        send_req(FN_FLUSH, 8'h5A, 11'h2AA);
        send_req(FN_COMMIT, 8'h00, 11'd0);       // commit with no transaction open
        send_req(FN_ROLLBACK, 8'h00, 11'd0);     // rollback with no transaction open
        send_req(FN_UNUSED, 8'h3C, 11'h555);
        // transaction: rollback discards the puts
        send_req(FN_BEGIN, 8'h00, 11'd0);
        send_req(FN_PUT, 8'h00, 11'd0);
        send_req(FN_PUT, 8'hFF, 11'h7FF);
        send_req(FN_ROLLBACK, 8'h00, 11'd0);
        // begin inside an open transaction rolls back first
        send_req(FN_BEGIN, 8'h00, 11'd0);
        send_req(FN_PUT, 8'h81, 11'd1);
        send_req(FN_BEGIN, 8'h00, 11'd0);
        send_req(FN_COMMIT, 8'h00, 11'd0);
        // Fill to capacity. Together with the wrap below this writes every store
        // entry, so later rollbacks never expose an entry that was never written.
        for (int i = 0; i < DEPTH - 1; i++) begin
            send_req(FN_PUT, 8'(i * 37), 11'(i));
        end
        send_req(FN_PUT, 8'h77, 11'd0);          // full, no chop policy -> overflow
        send_req(FN_GET, 8'h00, 11'd0);
        send_req(FN_PUT, 8'hE7, 11'd0);          // lands in the last entry, head wraps
        send_req(FN_GET, 8'h00, 11'd0);
        send_req(FN_REMOVE, 8'h00, 11'd5);
        send_req(FN_REMOVE, 8'h00, 11'd1024);    // more than held -> empties

        // --- random phases, each under its own register setting ---
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            idle_en   <= (p % 3) != 2;   // every third phase runs back to back
            with_size = 1'b1;
            case (p)
                0: begin mode = CHOP_CHAR; dchar = 8'h0A; clen = 11'd1;    csize = 11'd8;    end
                1: begin mode = CHOP_LEN;  dchar = 8'hFF; clen = 11'd3;    csize = 11'd16;   end
                2: begin mode = CHOP_LEN;  dchar = 8'h00; clen = 11'd0;    csize = 11'd2;    end
                3: begin mode = CHOP_UNKNOWN; dchar = 8'h55; clen = 11'h7FF; csize = 11'd0; end
                4: begin mode = CHOP_CHAR; dchar = 8'hFF; clen = 11'd1024; csize = 11'd1;    end
                5: begin mode = CHOP_CHAR; dchar = 8'h00; clen = 11'd5;    csize = 11'h7FF;  end
                6: begin mode = CHOP_LEN;  dchar = 8'hAA; clen = 11'd1024; csize = 11'd12;   end
                7: begin mode = CHOP_NONE; dchar = 8'h0D; clen = 11'd2;    csize = 11'd5;    end
                default: begin
                    mode      = 2'($urandom_range(0, 3));
                    dchar     = 8'($urandom);
                    clen      = 11'($urandom_range(0, 12));
                    csize     = 11'($urandom_range(2, 40));
                    with_size = $urandom_range(0, 2) != 0;   // sometimes keep ring contents
                end
            endcase

            // register writes back to back, enable held high across them
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_MODE;
            i_cfg_data <= 11'(mode);
            @(posedge i_clk);
            i_cfg_idx  <= CFG_CHAR;
            i_cfg_data <= 11'(dchar);
            @(posedge i_clk);
            i_cfg_idx  <= CFG_LEN;
            i_cfg_data <= clen;
            if (with_size) begin
                @(posedge i_clk);
                i_cfg_idx  <= CFG_SIZE;
                i_cfg_data <= csize;
                cur_size = (csize < 2) ? 2 : (csize > DEPTH) ? DEPTH : int'(csize);
            end
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            cur_mode = mode;
            cur_char = dchar;

            // all but the last back-to-back phase also get the long result stall, so the unit backs up
            if (p % 3 == 2 && p < 9) hold_req <= hold_req + 1;

            target = beats_sent + RANDOM_BEATS / PHASES;
            while (beats_sent < target) begin
                kind = $urandom_range(0, 9);
                if (kind <= 3) begin
                    // put run: fills small rings and drives the chop paths
                    n = $urandom_range(1, 12);
                    repeat (n) send_req(FN_PUT, pick_byte(), 11'($urandom));
                end else if (kind <= 5) begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_req(FN_GET, 8'($urandom), 11'($urandom));
                end else if (kind == 6) begin
                    // transaction closed by commit, rollback or a fresh begin
                    send_req(FN_BEGIN, 8'($urandom), 11'($urandom));
                    n = $urandom_range(0, 6);
                    repeat (n) send_req(FN_PUT, pick_byte(), 11'($urandom));
                    pick = $urandom_range(0, 4);
                    send_req((pick < 2) ? FN_COMMIT : (pick < 4) ? FN_ROLLBACK : FN_BEGIN,
                             8'($urandom), 11'($urandom));
                end else if (kind == 7) begin
                    // counts mostly around the fill, sometimes anywhere in the field
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                    : $urandom_range(0, cur_size + 1);
                    send_req(FN_REMOVE, 8'($urandom), 11'(n));
                end else if (kind == 8) begin
                    // noise: any func code, including the undecoded one
                    send_req(3'($urandom), 8'($urandom), 11'($urandom));
                end else begin
                    pick = $urandom_range(0, 2);
                    send_req((pick == 0) ? FN_FLUSH : (pick == 1) ? FN_COMMIT : FN_ROLLBACK,
                             8'($urandom), 11'($urandom));
                end
            end
        end

        wait_idle();
        // extra edges after the last result catch strays
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (full-ring delimiter scans,
    // long stalls on both sides, the hold-offs).
    initial begin
        #(40_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
